// ===== sv/lphs_pkg.sv =====
`default_nettype none

package lphs_pkg;

  // Table geometry. The home slot is taken from the low hash bits, so the
  // capacity is a power of two.
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CAPACITY - 1);

  localparam int KEY_W  = 64;
  localparam int HASH_W = 64;
  localparam int OP_W   = 2;
  localparam int CNT_W  = 9;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_RAW_W  = OP_W + KEY_W + HASH_W;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 1 + 1 + CNT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_TEST   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY     = 2'd0,
    SLOT_OCCUPIED  = 2'd1,
    SLOT_TOMBSTONE = 2'd2
  } slot_status_t;

  // One table entry: status in the top bits, then hash, then key.
  localparam int ENTRY_W = 2 + HASH_W + KEY_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic start;         // latch the input item and set up the probe
    logic read;          // read the slot under the probe pointer
    logic advance;       // step the probe to the next slot
    logic finish;        // commit the operation and load the result
    logic finish_clear;  // empty the table and load the result
  } lphs_cmd_t;

  typedef struct packed {
    logic in_clear;  // the item offered on the input is a clear
    logic stop;      // the probe ends at the slot just read
    logic out_free;  // the result register can take a new result
  } lphs_sts_t;

endpackage

`default_nettype wire

// ===== sv/lphs_ram.sv =====
`default_nettype none

module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lphs_ctrl.sv =====
`default_nettype none

module lphs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire lphs_pkg::lphs_sts_t sts,
  output      lphs_pkg::lphs_cmd_t cmd
);

  import lphs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = sts.in_clear ? S_CLEAR : S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.stop) begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (sts.out_free) begin
          cmd.finish_clear = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/lphs_dp.sv =====
`default_nettype none

module lphs_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [lphs_pkg::IN_W-1:0] s_tdata,
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  output      logic [lphs_pkg::OUT_W-1:0] m_tdata,
  input  wire lphs_pkg::lphs_cmd_t       cmd,
  output      lphs_pkg::lphs_sts_t       sts
);

  import lphs_pkg::*;

  op_t               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [HASH_W-1:0] hash_q;

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] step;
  logic              have_tomb;
  logic [ADDR_W-1:0] tomb_idx;

  logic [CAPACITY-1:0] slot_valid;
  logic                valid_q;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             out_status;
  logic             out_found;
  logic [CNT_W-1:0] out_count;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  slot_status_t      slot_st;
  logic              is_empty;
  logic              is_tomb;
  logic              is_match;
  logic              tomb_eff;
  logic [ADDR_W-1:0] tomb_eff_idx;
  logic              have_free;
  logic [ADDR_W-1:0] free_idx;
  logic              wr_add;
  logic              wr_del;
  logic              res_status;

  lphs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.read),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // A slot that was never written since reset or the last clear is empty,
  // whatever the memory holds.
  always_comb begin
    slot_st  = valid_q ? slot_status_t'(ram_rdata[ENTRY_W-1 -: 2]) : SLOT_EMPTY;
    is_empty = (slot_st == SLOT_EMPTY);
    is_tomb  = (slot_st == SLOT_TOMBSTONE);
    is_match = (slot_st == SLOT_OCCUPIED)
               && (ram_rdata[KEY_W +: HASH_W] == hash_q)
               && (ram_rdata[KEY_W-1:0] == key_q);

    tomb_eff     = have_tomb || is_tomb;
    tomb_eff_idx = have_tomb ? tomb_idx : addr;
    have_free    = is_empty || tomb_eff;
    free_idx     = tomb_eff ? tomb_eff_idx : addr;

    wr_add     = (op_q == OP_ADD) && !is_match && have_free;
    wr_del     = (op_q == OP_DELETE) && is_match;
    res_status = (op_q == OP_ADD) && !is_match && !have_free;

    ram_we    = cmd.finish && (wr_add || wr_del);
    ram_waddr = wr_add ? free_idx : addr;
    ram_wdata = {(wr_add ? SLOT_OCCUPIED : SLOT_TOMBSTONE), hash_q, key_q};

    if (wr_add) begin
      count_next = count + 1'b1;
    end else if (wr_del) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end

    sts.in_clear = (op_t'(s_tdata[OP_W-1:0]) == OP_CLEAR);
    sts.stop     = is_empty || is_match || (step == LAST_IDX);
    sts.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q   <= op_t'(s_tdata[OP_W-1:0]);
      key_q  <= s_tdata[OP_W +: KEY_W];
      hash_q <= s_tdata[OP_W+KEY_W +: HASH_W];
    end
    if (cmd.start) begin
      addr     <= s_tdata[OP_W+KEY_W +: ADDR_W];
      step     <= '0;
      tomb_idx <= '0;
    end else if (cmd.advance) begin
      addr <= (addr == LAST_IDX) ? '0 : addr + 1'b1;
      step <= step + 1'b1;
      if (is_tomb && !have_tomb) begin
        tomb_idx <= addr;
      end
    end
    if (cmd.read) begin
      valid_q <= slot_valid[addr];
    end
    if (cmd.finish || cmd.finish_clear) begin
      out_status <= cmd.finish && res_status;
      out_found  <= cmd.finish && is_match;
      out_count  <= cmd.finish ? count_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_tomb  <= 1'b0;
      slot_valid <= '0;
      count      <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.start) begin
        have_tomb <= 1'b0;
      end else if (cmd.advance && is_tomb) begin
        have_tomb <= 1'b1;
      end
      if (cmd.finish_clear) begin
        slot_valid <= '0;
        count      <= '0;
      end else if (cmd.finish) begin
        if (ram_we) begin
          slot_valid[ram_waddr] <= 1'b1;
        end
        count <= count_next;
      end
      if (cmd.finish || cmd.finish_clear) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(OUT_W - OUT_RAW_W)'(0), out_count, out_found, out_status};

endmodule

`default_nettype wire

// ===== sv/linear_probe_hash_set_top.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_*       input      s_tvalid / s_tready   one set operation: op, key, hash
// m_*       output     m_tvalid / m_tready   one result: status, found, count
//
// Every transaction on s_* yields exactly one transaction on m_*, in order.
// A clear skips the probe. Add, delete and test walk N slots, where N is
// the number of slots probed (1 to 256): each slot costs one read of the
// table memory and a compare of the registered entry.
// Reset empties the table at once through per-slot valid bits; there is no
// clearing pass, and clear works the same way.
// The result sits in an output register, so the next operation is accepted
// while it waits; a stalled m_tready holds only the commit of the operation
// after it.
module linear_probe_hash_set_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output      logic                       s_tready,
  // [1:0] operation, [65:2] key, [129:66] key_hash, rest zero
  input  wire logic [lphs_pkg::IN_W-1:0]  s_tdata,
  output      logic                       m_tvalid,
  input  wire logic                       m_tready,
  // [0] status, [1] found, [10:2] element_count, rest zero
  output      logic [lphs_pkg::OUT_W-1:0] m_tdata
);

  import lphs_pkg::*;

  lphs_cmd_t cmd;
  lphs_sts_t sts;

  // The controller sequences the probe: read a slot, check it, then either
  // step on or commit the operation and hand over the result.
  lphs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the table memory, the probe pointer, the first
  // tombstone seen, the element count and the result register.
  lphs_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .sts     (sts)
  );

  // The controller issues at most one command in a cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.read, cmd.advance, cmd.finish, cmd.finish_clear}))
    else $error("controller issued more than one command");

  // Only one operation is in flight: after an accept the input is closed.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an operation is in flight");

  // The element count never exceeds the table capacity.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:2] <= 9'(CAPACITY)))
    else $error("element count beyond capacity");

  // A full table is reported only for a key that was not found.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> !m_tdata[1])
    else $error("full status together with found");

endmodule

`default_nettype wire

// ===== sim/tb_linear_probe_hash_set_top.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_hash_set_top;
  import lphs_pkg::*;

  // One result as the block reports it on m_tdata.
  typedef struct packed {
    logic             status;
    logic             found;
    logic [CNT_W-1:0] count;
  } set_reply_t;

  // Predicts the hash set and checks every reply against it. The table is
  // kept slot for slot, so probe order, tombstone reuse and wraparound all
  // follow the block exactly.
  class hash_set_scoreboard;
    slot_status_t     slot_state [CAPACITY];
    logic [KEY_W-1:0]  slot_key  [CAPACITY];
    logic [HASH_W-1:0] slot_hash [CAPACITY];
    int unsigned       live_count;
    set_reply_t        expected_replies [$];
    int unsigned       mismatches;
    int unsigned       replies_checked;
    int unsigned       ops_seen [4];
    int unsigned       full_adds;
    int unsigned       key_hits;
    int unsigned       peak_count;

    function new();
      foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
      live_count = 0;
      mismatches = 0;
      replies_checked = 0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
      full_adds = 0;
      key_hits = 0;
      peak_count = 0;
    endfunction

    // Applies one operation to the predicted table and returns its reply.
    function set_reply_t apply_op(op_t op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
      set_reply_t reply;
      int slot;
      int first_tomb;
      int hit;
      int free_slot;
      reply = '0;
      if (op == OP_CLEAR) begin
        foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
        live_count = 0;
        return reply;
      end
      slot = int'(hash[ADDR_W-1:0]);
      first_tomb = -1;
      hit = -1;
      free_slot = -1;
      // Walk at most one lap; stop at an empty slot or a hash-and-key match.
      for (int step = 0; step < CAPACITY && hit < 0 && free_slot < 0; step++) begin
        case (slot_state[slot])
          SLOT_EMPTY: begin
            free_slot = (first_tomb >= 0) ? first_tomb : slot;
          end
          SLOT_TOMBSTONE: begin
            if (first_tomb < 0) first_tomb = slot;
          end
          SLOT_OCCUPIED: begin
            if (slot_hash[slot] == hash && slot_key[slot] == key) hit = slot;
          end
          default: ;
        endcase
        slot = (slot + 1) % CAPACITY;
      end
      // A full lap without an empty slot may still have passed a tombstone.
      if (hit < 0 && free_slot < 0) free_slot = first_tomb;
      reply.found = (hit >= 0);
      if (op == OP_ADD && hit < 0) begin
        if (free_slot >= 0) begin
          slot_state[free_slot] = SLOT_OCCUPIED;
          slot_key[free_slot] = key;
          slot_hash[free_slot] = hash;
          live_count++;
        end else begin
          reply.status = 1'b1;
        end
      end else if (op == OP_DELETE && hit >= 0) begin
        slot_state[hit] = SLOT_TOMBSTONE;
        live_count--;
      end
      reply.count = CNT_W'(live_count);
      return reply;
    endfunction

    // Called for every accepted input transaction.
    function void accept_op(op_t op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
      set_reply_t reply;
      reply = apply_op(op, key, hash);
      expected_replies.push_back(reply);
      ops_seen[op]++;
      if (reply.status) full_adds++;
      if (reply.found) key_hits++;
      if (live_count > peak_count) peak_count = live_count;
    endfunction

    // Called for every accepted output transaction.
    function void check_result(logic [OUT_W-1:0] data);
      set_reply_t want;
      set_reply_t got;
      got.status = data[0];
      got.found = data[1];
      got.count = data[2 +: CNT_W];
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status=%0b found=%0b count=%0d",
                   $realtime, got.status, got.found, got.count);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.found !== want.found || got.count !== want.count)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d mismatch: status %0b/%0b found %0b/%0b count %0d/%0d %s",
                   $realtime, replies_checked, want.status, got.status, want.found,
                   got.found, want.count, got.count, "(expected/actual)");
      end
      replies_checked++;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES   = 600;   // longer than a full-lap probe
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off for back-pressure

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;

  hash_set_scoreboard sb;
  int unsigned        idle_cycles;
  int unsigned        results_seen;
  bit                 gaps_on;

  // Stimulus pools: a cluster of keys for the random rounds, and the keys
  // used to fill the whole table.
  logic [KEY_W-1:0]  pool_key  [64];
  logic [HASH_W-1:0] pool_hash [64];
  logic [KEY_W-1:0]  fill_key  [CAPACITY];
  logic [HASH_W-1:0] fill_hash [CAPACITY];

  linear_probe_hash_set_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sender gap: mostly none or short, now and then a long one. Some rounds
  // run with no gaps at all.
  function automatic int pick_gap();
    int sel;
    if (!gaps_on) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one operation and returns once the block has taken it. The
  // fields are packed op, key, hash from the low bit up.
  task automatic send_op(op_t op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
    logic [IN_W-1:0] word;
    word = '0;
    word[OP_W-1:0] = op;
    word[OP_W +: KEY_W] = key;
    word[OP_W + KEY_W +: HASH_W] = hash;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // Idle cycles on the input; the data lines carry junk meanwhile, which the
  // block must ignore.
  task automatic idle_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata <= {8'($urandom), rand64(), rand64()};
    end
  endtask

  task automatic send_with_gap(op_t op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
    send_op(op, key, hash);
    idle_gap(pick_gap());
  endtask

  // Short directed sequence: empty-table miss, duplicate add, key extremes,
  // home slots at the top of the table so that probes wrap, equal keys with
  // different hashes, tombstone skip and reuse, delete of an absent key,
  // and clear.
  task automatic run_directed();
    logic [63:0] ones;
    ones = '1;
    send_with_gap(OP_TEST,   64'd0, 64'd0);
    send_with_gap(OP_ADD,    64'd0, 64'd0);
    send_with_gap(OP_ADD,    64'd0, 64'd0);           // already present
    send_with_gap(OP_ADD,    ones,  ones);            // lands in the last slot
    send_with_gap(OP_ADD,    64'd5, ones);            // same home, wraps past slot 0
    send_with_gap(OP_ADD,    ones,  64'hFF);          // same key, other hash
    send_with_gap(OP_TEST,   64'd5, ones);
    send_with_gap(OP_DELETE, 64'd0, 64'd0);           // leaves a tombstone in slot 0
    send_with_gap(OP_DELETE, 64'd0, 64'd0);           // now absent
    send_with_gap(OP_TEST,   64'd5, ones);            // probe steps over the tombstone
    send_with_gap(OP_ADD,    64'd7, 64'hFF);          // reuses the tombstone
    send_with_gap(OP_TEST,   64'd7, 64'hFF);
    send_with_gap(OP_TEST,   64'd0, 64'd0);
    send_with_gap(OP_ADD,    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_with_gap(OP_ADD,    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_with_gap(OP_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_with_gap(OP_CLEAR,  ones,  ones);
    send_with_gap(OP_TEST,   ones,  ones);
    send_with_gap(OP_ADD,    ones,  ones);
    send_with_gap(OP_CLEAR,  64'd0, 64'd0);
  endtask

  // Fills every slot, then probes the full table: add with no free slot,
  // misses that walk a whole lap, duplicate add on a full table, and
  // tombstone reuse found only after a full lap. Then all fill keys are deleted
  // so that the table holds tombstones, the spare key and no empty slot.
  task automatic run_full_table();
    int pick;
    logic [63:0] spare_key;
    logic [63:0] spare_hash;
    gaps_on = 1'b1;
    send_with_gap(OP_CLEAR, rand64(), rand64());
    for (int i = 0; i < CAPACITY; i++) begin
      fill_key[i] = rand64();
      fill_hash[i] = rand64();
      send_with_gap(OP_ADD, fill_key[i], fill_hash[i]);
    end
    pick = $urandom_range(0, CAPACITY - 1);
    spare_key = rand64();
    spare_hash = rand64();
    send_with_gap(OP_ADD,    spare_key, spare_hash);          // table full
    send_with_gap(OP_TEST,   rand64(), rand64());
    send_with_gap(OP_DELETE, rand64(), rand64());
    send_with_gap(OP_TEST,   fill_key[pick], fill_hash[pick]);
    send_with_gap(OP_ADD,    fill_key[pick], fill_hash[pick]);
    send_with_gap(OP_DELETE, fill_key[pick], fill_hash[pick]);
    send_with_gap(OP_ADD,    spare_key, spare_hash);          // takes the lone tombstone
    for (int i = 0; i < CAPACITY; i++)
      send_with_gap(OP_DELETE, fill_key[i], fill_hash[i]);
    send_with_gap(OP_TEST,   fill_key[pick], fill_hash[pick]);
    send_with_gap(OP_ADD,    rand64(), rand64());
    send_with_gap(OP_TEST,   spare_key, spare_hash);
    send_with_gap(OP_CLEAR,  rand64(), rand64());
  endtask

  // One random round on a cluster of keys whose home slots crowd into a
  // narrow window, so probes run long and cross tombstones. Some keys share
  // a key or a hash with another. A few items are noise or clears.
  task automatic run_round(int n_items);
    int pool_n;
    int base;
    int spread;
    int sel;
    int pick;
    op_t op;
    pool_n = $urandom_range(8, 64);
    base = $urandom_range(0, CAPACITY - 1);
    spread = $urandom_range(4, 96);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int j = 0; j < pool_n; j++) begin
      pool_key[j] = rand64();
      pool_hash[j] = rand64();
      pool_hash[j][ADDR_W-1:0] = ADDR_W'(base + $urandom_range(0, spread));
      if (j > 0 && $urandom_range(0, 7) == 0)
        pool_key[j] = pool_key[$urandom_range(0, j - 1)];
      else if (j > 0 && $urandom_range(0, 7) == 0)
        pool_hash[j] = pool_hash[$urandom_range(0, j - 1)];
    end
    for (int j = 0; j < n_items; j++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        send_with_gap(OP_CLEAR, rand64(), rand64());
      end else if (sel < 15) begin
        send_with_gap(op_t'($urandom_range(0, 2)), rand64(), rand64());
      end else begin
        pick = $urandom_range(0, pool_n - 1);
        sel = $urandom_range(0, 99);
        op = (sel < 45) ? OP_ADD : (sel < 70) ? OP_DELETE : OP_TEST;
        send_with_gap(op, pool_key[pick], pool_hash[pick]);
      end
    end
  endtask

  // Receiver: random stalls, ready stretches and long stalls. Twice in the
  // run it holds off for a long stretch so that the output register fills
  // and the block stops taking input.
  initial begin : ready_driver
    int len;
    int sel;
    int hold_idx;
    int hold_at [2];
    hold_at[0] = 60;
    hold_at[1] = 700;
    hold_idx = 0;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_idx < 2 && results_seen >= hold_at[hold_idx]) begin
        hold_idx++;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 5) begin
          len = $urandom_range(10, 60);
          repeat (len) begin
            @(negedge clk);
            m_tready <= 1'b1;
          end
        end else if (sel == 19) begin
          len = $urandom_range(20, 80);
          repeat (len) begin
            @(negedge clk);
            m_tready <= 1'b0;
          end
        end else begin
          @(negedge clk);
          m_tready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // Monitor: note every accepted transaction at the rising edge, and run
  // the watchdog on cycles where neither side moves anything.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready)
        sb.accept_op(op_t'(s_tdata[OP_W-1:0]), s_tdata[OP_W +: KEY_W],
                     s_tdata[OP_W + KEY_W +: HASH_W]);
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        results_seen <= results_seen + 1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
                 $realtime, idle_cycles, sb.pending());
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : main
    sb = new();
    results_seen = 0;
    gaps_on = 1'b1;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_full_table();
    for (int r = 0; r < 4; r++)
      run_round(60);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Any stray result would show up within one full-lap probe.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d add, %0d delete, %0d test, %0d clear; %0d results checked.",
             sb.ops_seen[OP_ADD] + sb.ops_seen[OP_DELETE] + sb.ops_seen[OP_TEST]
             + sb.ops_seen[OP_CLEAR], sb.ops_seen[OP_ADD], sb.ops_seen[OP_DELETE],
             sb.ops_seen[OP_TEST], sb.ops_seen[OP_CLEAR], sb.replies_checked);
    $display("Adds refused on a full table: %0d, keys found: %0d, peak occupancy %0d, %s %0d.",
             sb.full_adds, sb.key_hits, sb.peak_count, "mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
